// ----- src/pearson_correlation_top_macros.svh -----
// Assertion macros for the correlation block.
// Used by the controller; needs clk and rst in scope of the caller.
`ifndef PEARSON_CORRELATION_TOP_MACROS_SVH
`define PEARSON_CORRELATION_TOP_MACROS_SVH
// Same-cycle implication
`define PC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define PC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/pc_pkg.sv -----
// Shared types and constants for the correlation block.
// No dependencies.
`default_nettype none
package pc_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_PAIRS = 65536;
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SQ_W = PROD_W - 2 + CNT_W;
  localparam int CROSS_W = SQ_W + 1;
  localparam int WORD_W = 64;
  localparam int MUL_A_W = 2 * WORD_W;
  localparam int MUL_B_W = WORD_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CW = $clog2(MUL_B_W + 1);
  localparam int RHS_W = MUL_A_W + 32;
  localparam int COEF_W = 16;
  localparam int BIT_W = $clog2(COEF_W);
  localparam int D_W = COEF_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NSXX,
    OP_SXSX,
    OP_NSYY,
    OP_SYSY,
    OP_NSXY,
    OP_SXSY,
    OP_VXVY,
    OP_MAGSQ,
    OP_DSQ,
    OP_TRIAL
  } op_t;

  typedef struct packed {
    logic acc_en;
    logic clear;
    logic mul_start;
    op_t  op;
    logic bit_init;
    logic bit_next;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic ok;
    logic bit_last;
  } stat_t;
endpackage
`default_nettype wire

// ----- src/pc_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on pc_pkg.
`default_nettype none
module pc_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pc_pkg::MUL_A_W-1:0] a,
  input  wire logic [pc_pkg::MUL_B_W-1:0] b,
  output logic                            done,
  output logic [pc_pkg::MUL_P_W-1:0]      product
);
  import pc_pkg::*;

  logic [MUL_P_W-1:0] ma;
  logic [MUL_B_W-1:0] mb;
  logic [MUL_CW-1:0]  cnt;
  logic               running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == MUL_CW'(1)) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma <= {{MUL_B_W{1'b0}}, a};
      mb <= b;
      product <= '0;
      cnt <= MUL_CW'(MUL_B_W);
    end else if (running) begin
      if (mb[0]) begin
        product <= product + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
      cnt <= cnt - MUL_CW'(1);
    end
  end
endmodule
`default_nettype wire

// ----- src/pc_datapath.sv -----
// Datapath: running sums, variance terms, root search and result registers.
// Depends on pc_pkg and pc_mul.
`default_nettype none
module pc_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pc_pkg::cmd_t                   cmd,
  output pc_pkg::stat_t                       stat,
  input  wire logic signed [pc_pkg::SAMPLE_BITS-1:0] sample_x,
  input  wire logic signed [pc_pkg::SAMPLE_BITS-1:0] sample_y,
  output logic                                valid,
  output logic signed [pc_pkg::COEF_W-1:0]    coefficient,
  output logic                                defined
);
  import pc_pkg::*;

  logic [CNT_W-1:0]          pair_count;
  logic signed [SUM_W-1:0]   sum_first, sum_second;
  logic signed [CROSS_W-1:0] sum_cross;
  logic [SQ_W-1:0]           sum_first_sq, sum_second_sq;
  logic                      count_overflow;

  logic signed [PROD_W-1:0]  pxx, pyy, pxy;
  logic [WORD_W-1:0]         n64, sx64, sy64, sxx64, syy64, sxy64;
  logic [WORD_W-1:0]         tmp, vx, vy, num, mag, dsq;
  logic [MUL_A_W-1:0]        v;
  logic [RHS_W-1:0]          rhs;
  logic [COEF_W-1:0]         q, cand;
  logic [BIT_W-1:0]          bit_idx;
  logic [D_W-1:0]            d;
  logic [D_W-1:0]            qc;
  logic [COEF_W-1:0]         coef_next;

  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_done;
  logic [MUL_P_W-1:0]        mul_p;

  pc_mul u_mul (
    .clk(clk),
    .rst(rst),
    .start(cmd.mul_start),
    .a(mul_a),
    .b(mul_b),
    .done(mul_done),
    .product(mul_p)
  );

  assign pxx = sample_x * sample_x;
  assign pyy = sample_y * sample_y;
  assign pxy = sample_x * sample_y;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pair_count <= '0;
      sum_first <= '0;
      sum_second <= '0;
      sum_cross <= '0;
      sum_first_sq <= '0;
      sum_second_sq <= '0;
      count_overflow <= 1'b0;
    end else if (cmd.acc_en) begin
      if (pair_count >= CNT_W'(MAX_PAIRS)) begin
        count_overflow <= 1'b1;
      end else begin
        pair_count <= pair_count + CNT_W'(1);
        sum_first <= sum_first + {{(SUM_W-SAMPLE_BITS){sample_x[SAMPLE_BITS-1]}}, sample_x};
        sum_second <= sum_second + {{(SUM_W-SAMPLE_BITS){sample_y[SAMPLE_BITS-1]}}, sample_y};
        sum_cross <= sum_cross + {{(CROSS_W-PROD_W){pxy[PROD_W-1]}}, pxy};
        sum_first_sq <= sum_first_sq + {{(SQ_W-PROD_W){1'b0}}, pxx};
        sum_second_sq <= sum_second_sq + {{(SQ_W-PROD_W){1'b0}}, pyy};
      end
    end
  end

  assign n64   = {{(WORD_W-CNT_W){1'b0}}, pair_count};
  assign sx64  = {{(WORD_W-SUM_W){sum_first[SUM_W-1]}}, sum_first};
  assign sy64  = {{(WORD_W-SUM_W){sum_second[SUM_W-1]}}, sum_second};
  assign sxy64 = {{(WORD_W-CROSS_W){sum_cross[CROSS_W-1]}}, sum_cross};
  assign sxx64 = {{(WORD_W-SQ_W){1'b0}}, sum_first_sq};
  assign syy64 = {{(WORD_W-SQ_W){1'b0}}, sum_second_sq};

  assign mag  = num[WORD_W-1] ? (WORD_W'(0) - num) : num;
  assign cand = q | (COEF_W'(1) << bit_idx);
  assign d    = {cand, 1'b0} - D_W'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_NSXX:  begin mul_a = {{WORD_W{1'b0}}, n64};  mul_b = sxx64; end
      OP_SXSX:  begin mul_a = {{WORD_W{1'b0}}, sx64}; mul_b = sx64;  end
      OP_NSYY:  begin mul_a = {{WORD_W{1'b0}}, n64};  mul_b = syy64; end
      OP_SYSY:  begin mul_a = {{WORD_W{1'b0}}, sy64}; mul_b = sy64;  end
      OP_NSXY:  begin mul_a = {{WORD_W{1'b0}}, n64};  mul_b = sxy64; end
      OP_SXSY:  begin mul_a = {{WORD_W{1'b0}}, sx64}; mul_b = sy64;  end
      OP_VXVY:  begin mul_a = {{WORD_W{1'b0}}, vx};   mul_b = vy;    end
      OP_MAGSQ: begin mul_a = {{WORD_W{1'b0}}, mag};  mul_b = mag;   end
      OP_DSQ: begin
        mul_a = {{(MUL_A_W-D_W){1'b0}}, d};
        mul_b = {{(MUL_B_W-D_W){1'b0}}, d};
      end
      OP_TRIAL: begin mul_a = v; mul_b = dsq; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.op)
        OP_NSXX, OP_NSYY, OP_NSXY: tmp <= mul_p[WORD_W-1:0];
        OP_SXSX:  vx  <= tmp - mul_p[WORD_W-1:0];
        OP_SYSY:  vy  <= tmp - mul_p[WORD_W-1:0];
        OP_SXSY:  num <= tmp - mul_p[WORD_W-1:0];
        OP_VXVY:  v   <= mul_p[MUL_A_W-1:0];
        OP_MAGSQ: rhs <= {mul_p[MUL_A_W-1:0], 32'b0};
        OP_DSQ:   dsq <= mul_p[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bit_init) begin
      q <= '0;
      bit_idx <= BIT_W'(COEF_W - 1);
    end else begin
      if (mul_done && cmd.op == OP_TRIAL &&
          mul_p <= {{(MUL_P_W-RHS_W){1'b0}}, rhs}) begin
        q <= cand;
      end
      if (cmd.bit_next) begin
        bit_idx <= bit_idx - BIT_W'(1);
      end
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.ok = !count_overflow && pair_count >= CNT_W'(2) &&
                   vx != '0 && vy != '0;
  assign stat.bit_last = bit_idx == '0;

  always_comb begin
    qc = {1'b0, q};
    if (num[WORD_W-1]) begin
      if (qc > (D_W'(1) << (COEF_W - 1))) begin
        qc = D_W'(1) << (COEF_W - 1);
      end
      coef_next = COEF_W'(D_W'(0) - qc);
    end else begin
      if (qc > ((D_W'(1) << (COEF_W - 1)) - D_W'(1))) begin
        qc = (D_W'(1) << (COEF_W - 1)) - D_W'(1);
      end
      coef_next = qc[COEF_W-1:0];
    end
    if (!stat.ok) begin
      coef_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      coefficient <= coef_next;
      defined <= stat.ok;
    end
  end
endmodule
`default_nettype wire

// ----- src/pc_ctrl.sv -----
// Controller: sequences accumulation, the variance multiplies and the root search.
// Depends on pc_pkg and the assertion macro header.
`default_nettype none
`include "pearson_correlation_top_macros.svh"
module pc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          last,
  output logic               busy,
  output pc_pkg::cmd_t       cmd,
  input  wire pc_pkg::stat_t stat
);
  import pc_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_NSXX;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    cmd.op = op;
    unique case (state)
      ST_IDLE: begin
        cmd.acc_en = start;
        if (start && last) begin
          op_next = OP_NSXX;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.mul_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.mul_done) begin
          state_next = ST_START;
          unique case (op)
            OP_NSXX:  op_next = OP_SXSX;
            OP_SXSX:  op_next = OP_NSYY;
            OP_NSYY:  op_next = OP_SYSY;
            OP_SYSY:  op_next = OP_NSXY;
            OP_NSXY:  op_next = OP_SXSY;
            OP_SXSY:  state_next = ST_CHECK;
            OP_VXVY:  op_next = OP_MAGSQ;
            OP_MAGSQ: begin
              cmd.bit_init = 1'b1;
              op_next = OP_DSQ;
            end
            OP_DSQ:   op_next = OP_TRIAL;
            OP_TRIAL: begin
              if (stat.bit_last) begin
                state_next = ST_EMIT;
              end else begin
                cmd.bit_next = 1'b1;
                op_next = OP_DSQ;
              end
            end
            default:  state_next = ST_EMIT;
          endcase
        end
      end
      ST_CHECK: begin
        if (stat.ok) begin
          op_next = OP_VXVY;
          state_next = ST_START;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.clear = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = state != ST_IDLE;

  `PC_ASSERT_NEXT(a_emit_idle, cmd.emit, state == ST_IDLE, "emit not followed by idle")
  `PC_ASSERT_NOW(a_done_wait, stat.mul_done, state == ST_WAIT, "multiply done outside wait")
  `PC_ASSERT_NEXT(a_last_busy, start && !busy && last, busy, "last item did not start compute")
  `PC_ASSERT_NOW(a_clear_emit, cmd.clear, cmd.emit && !cmd.acc_en, "clear without emit")
endmodule
`default_nettype wire

// ----- src/pearson_correlation_top.sv -----
// Operation: items are accumulated while idle; on the last item the block stays busy
// for 40 multiplies on one shift-add multiplier, or only for the variance multiplies
// when the result is undefined. The result strobe is registered and rises as busy falls.
// Throughput: one item per cycle between sets; the receiver cannot stall.
// Reset: synchronous, active high, clears all sums and returns to idle.
`default_nettype none
module pearson_correlation_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [pc_pkg::SAMPLE_BITS-1:0] sample_x,
  input  wire logic signed [pc_pkg::SAMPLE_BITS-1:0] sample_y,
  input  wire logic                                  last,
  output logic                                       valid,
  output logic signed [pc_pkg::COEF_W-1:0]           coefficient,
  output logic                                       defined
);
  import pc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .last(last),
    .busy(busy),
    .cmd(cmd),
    .stat(stat)
  );

  pc_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .stat(stat),
    .sample_x(sample_x),
    .sample_y(sample_y),
    .valid(valid),
    .coefficient(coefficient),
    .defined(defined)
  );
endmodule
`default_nettype wire

// ----- test/pearson_correlation_checker.sv -----
// Checker for the correlation block: watches accepted items and result strobes,
// predicts each coefficient from running sums and compares it field by field.
// Depends on pc_pkg for the sample and coefficient widths.
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_checker (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic                                  busy,
  input  wire logic signed [pc_pkg::SAMPLE_BITS-1:0] sample_x,
  input  wire logic signed [pc_pkg::SAMPLE_BITS-1:0] sample_y,
  input  wire logic                                  last,
  input  wire logic                                  valid,
  input  wire logic signed [pc_pkg::COEF_W-1:0]      coefficient,
  input  wire logic                                  defined,
  output int                                         errors,
  output int                                         pending,
  output int                                         items_seen,
  output int                                         defined_seen
);
  import pc_pkg::*;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic              ok;
  } corr_t;

  corr_t       corr_q[$];
  logic [63:0] n_pairs, s_x, s_y, s_xy, s_xx, s_yy;
  bit          n_over;
  int          mismatches;

  function automatic corr_t corr_of_set();
    logic [63:0]  vx, vy, num, mag, dd, cand, q;
    logic [255:0] v, rhs, lhs;
    corr_t        r;
    vx = n_pairs * s_xx - s_x * s_x;
    vy = n_pairs * s_yy - s_y * s_y;
    num = n_pairs * s_xy - s_x * s_y;
    r.ok = !n_over && n_pairs >= 2 && vx != 0 && vy != 0;
    r.coef = '0;
    if (r.ok) begin
      mag = num[63] ? -num : num;
      v = 256'(vx) * 256'(vy);
      rhs = (256'(mag) * 256'(mag)) << 32;
      q = 0;
      for (int b = 15; b >= 0; b--) begin
        cand = q | (64'd1 << b);
        dd = 2 * cand - 1;
        lhs = 256'(dd * dd) * v;
        if (lhs <= rhs) q = cand;
      end
      if (q > 32768) q = 32768;
      if (num[63]) begin
        r.coef = COEF_W'(-q);
      end else begin
        if (q > 32767) q = 32767;
        r.coef = COEF_W'(q);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [63:0] xs, ys;
    corr_t       e;
    if (rst) begin
      n_pairs = 0; s_x = 0; s_y = 0; s_xy = 0; s_xx = 0; s_yy = 0;
      n_over = 0;
    end else begin
      if (valid) begin
        if (corr_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %0d/%0d", coefficient, defined);
        end else begin
          e = corr_q.pop_front();
          if (e.coef !== coefficient || e.ok !== defined) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: coefficient exp %0d got %0d, defined exp %0d got %0d",
                       $signed(e.coef), coefficient, e.ok, defined);
          end
        end
      end
      if (start && !busy) begin
        items_seen++;
        xs = {{48{sample_x[15]}}, sample_x};
        ys = {{48{sample_y[15]}}, sample_y};
        if (n_pairs >= MAX_PAIRS) begin
          n_over = 1;
        end else begin
          n_pairs = n_pairs + 1;
          s_x = s_x + xs; s_y = s_y + ys;
          s_xy = s_xy + xs * ys; s_xx = s_xx + xs * xs; s_yy = s_yy + ys * ys;
        end
        if (last) begin
          e = corr_of_set();
          defined_seen += e.ok;
          corr_q = {corr_q, e};
          n_pairs = 0; s_x = 0; s_y = 0; s_xy = 0; s_xx = 0; s_yy = 0;
          n_over = 0;
        end
      end
    end
    pending <= corr_q.size();
  end

  initial begin
    errors = 0; pending = 0; items_seen = 0; defined_seen = 0; mismatches = 0;
  end
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench top for the correlation block: drives sets of sample pairs and gives
// the verdict. Depends on pc_pkg, pearson_correlation_top and the checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import pc_pkg::*;

  logic                          clk, rst, start, last;
  logic signed [SAMPLE_BITS-1:0] sample_x, sample_y;
  logic                          busy, valid, defined;
  logic signed [COEF_W-1:0]      coefficient;
  int                            errors, pending, items_seen, defined_seen;
  int                            sets_sent;
  bit                            quiet;

  pearson_correlation_top dut (.*);

  pearson_correlation_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[pearson_correlation_top] ERROR");
    $finish;
  end

  task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input bit l);
    if (!quiet && $urandom_range(99) < 23) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    sample_x <= x;
    sample_y <= y;
    last <= l;
    do @(posedge clk); while (busy);
    if (l) sets_sent++;
  endtask

  task automatic send_rand_set(input int len);
    int          kind;
    logic [15:0] x, y, cx;
    kind = $urandom_range(9);
    cx = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      x = 16'($urandom);
      y = 16'($urandom);
      case (kind)
        0: y = x + 16'($urandom_range(0, 200)) - 16'd100;
        1: y = -x;
        2: x = cx;
        3: begin x = $urandom_range(0, 1) ? 16'h7fff : 16'h8000; y = x ^ 16'(i); end
        4: begin x = 16'($signed(16'($urandom_range(0, 15))) - 8); y = 16'(x * 3); end
        default: ;
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  initial begin
    start = 0; sample_x = 0; sample_y = 0; last = 0; sets_sent = 0; quiet = 0;
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;
    send_pair(16'h1234, 16'h4321, 1);
    send_pair(16'h7fff, 16'h7fff, 0);
    send_pair(16'h8000, 16'h8000, 1);
    send_pair(16'h7fff, 16'h8000, 0);
    send_pair(16'h8000, 16'h7fff, 1);
    send_pair(16'h0005, 16'h0001, 0);
    send_pair(16'h0005, 16'h7000, 0);
    send_pair(16'h0005, 16'h8001, 1);
    send_pair(16'h0001, 16'h0000, 0);
    send_pair(16'h0002, 16'h0000, 1);
    send_pair(16'hffff, 16'h0001, 0);
    send_pair(16'h0000, 16'hfffe, 0);
    send_pair(16'h5555, 16'haaaa, 0);
    send_pair(16'haaaa, 16'h5555, 1);
    while (items_seen < 1800) begin
      quiet = items_seen > 700 && items_seen < 1100;
      send_rand_set($urandom_range(0, 9) == 0 ? $urandom_range(1, 2)
                                              : $urandom_range(3, 40));
    end
    quiet = 1;
    send_rand_set(5);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    $display("covered %0d pairs in %0d sets, %0d with a defined coefficient",
             items_seen, sets_sent, defined_seen);
    if (errors == 0 && pending == 0) begin
      $display("[pearson_correlation_top] OK");
    end else begin
      $display("[pearson_correlation_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
